// File: hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// shared types and constants of the merge sort engine
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned MSE_DATA_W = 32;
	localparam int unsigned MSE_DEPTH  = 64;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PRIME,
		ST_MERGE,
		ST_EMIT
	} mse_state_t;

endpackage

// File: hdl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// element memory: one write port, two read ports, read data registered
// ----------------------------------------------------------------------------
module mse_ram import mse_pkg::*; #(
	parameter int unsigned DEPTH = MSE_DEPTH,
	parameter int unsigned W     = MSE_DATA_W
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [W-1:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [W-1:0]               rdata_a,
	output logic [W-1:0]               rdata_b
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hdl/merge_sort_engine_core.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// collects a set of signed words, sorts it ascending by bottom-up merge
// passes between two memories, then streams the sorted set out
// ----------------------------------------------------------------------------
//  channel | dir | tdata              | tlast      | tuser
//  s_*     | in  | [31:0] value       | last       | -
//  m_*     | out | [31:0] sorted_value| final_res  | overflow
//
//  load: one request per cycle into memory 0, s_tready high only while loading
//  sort: ceil(log2 n) passes, each a prime step, then one merged element
//    per cycle, bound by the single write port of the target memory,
//    plus a final prime step
//  emit: one result per cycle while m_tready is high, from a prefetched read
//  reset: control state clears at once; memories are not cleared, only
//    written entries are ever read
//  stalls: m_tready low holds the output register and the emission pointer
// ----------------------------------------------------------------------------
module merge_sort_engine_core import mse_pkg::*; #(
	parameter int unsigned DEPTH = MSE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] value
	input  logic        s_tlast,    // last element of the set
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] sorted_value
	output logic        m_tlast,    // final_res
	output logic        m_tuser     // [0] overflow
);

	// address, count and pointer widths
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = AW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	mse_state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;     // elements held
	logic          drop_q, drop_d;       // some element was dropped
	logic          sel_q, sel_d;         // memory holding the current runs
	logic [EW-1:0] w_q, w_d;             // run width of this pass
	logic [EW-1:0] a_ptr_q, a_nxt;       // head of first run, also emit pointer
	logic [EW-1:0] b_ptr_q, b_nxt;       // head of second run
	logic [EW-1:0] a_end_q, a_end_d;     // end (exclusive) of first run
	logic [EW-1:0] b_end_q, b_end_d;     // end (exclusive) of second run
	logic [CW-1:0] k_q, k_d;             // merge write index

	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;
	logic          m_tlast_q;
	logic          m_tuser_q;

	logic          s_acc;
	logic          out_ld;
	logic          we0, we1;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [31:0]   r0a, r0b, r1a, r1b;
	logic [31:0]   rda, rdb, pick;
	logic          take_a;
	logic [EW-1:0] n_e, w2, nxt_a_end, nxt_b_end;

	// two element memories, ping-pong between passes
	mse_ram #(.DEPTH(DEPTH), .W(32)) u_ram0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (a_nxt[AW-1:0]),
		.raddr_b (b_nxt[AW-1:0]),
		.rdata_a (r0a),
		.rdata_b (r0b)
	);

	mse_ram #(.DEPTH(DEPTH), .W(32)) u_ram1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (a_nxt[AW-1:0]),
		.raddr_b (b_nxt[AW-1:0]),
		.rdata_a (r1a),
		.rdata_b (r1b)
	);

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;

	// read data belongs to the pointers held this cycle
	assign rda  = sel_q ? r1a : r0a;
	assign rdb  = sel_q ? r1b : r0b;
	assign n_e  = EW'(count_q);
	assign w2   = w_q << 1;

	// take the first run on ties, the second run once the first is used up
	assign take_a = (a_ptr_q < a_end_q) &&
		((b_ptr_q >= b_end_q) || !($signed(rdb) < $signed(rda)));
	assign pick = take_a ? rda : rdb;

	// bounds of the next block in the same pass, clipped to the set size
	assign nxt_a_end = ((b_end_q + w_q) < n_e) ? (b_end_q + w_q) : n_e;
	assign nxt_b_end = ((b_end_q + w2) < n_e) ? (b_end_q + w2) : n_e;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		drop_d  = drop_q;
		sel_d   = sel_q;
		w_d     = w_q;
		a_nxt   = a_ptr_q;
		b_nxt   = b_ptr_q;
		a_end_d = a_end_q;
		b_end_d = b_end_q;
		k_d     = k_q;
		out_ld  = 1'b0;
		we0     = 1'b0;
		we1     = 1'b0;
		waddr   = k_q[AW-1:0];
		wdata   = pick;
		unique case (state_q)
			ST_LOAD: begin
				if (s_acc) begin
					if (count_q < DEPTH_C) begin
						we0     = 1'b1;
						waddr   = count_q[AW-1:0];
						wdata   = s_tdata;
						count_d = count_q + 1'b1;
					end else begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						state_d = ST_PRIME;
						w_d     = EW'(1);
						sel_d   = 1'b0;
					end
				end
			end
			ST_PRIME: begin
				// issue reads for the first block of the pass, or the first result
				a_nxt = '0;
				if (w_q >= n_e) begin
					state_d = ST_EMIT;
				end else begin
					b_nxt   = w_q;
					a_end_d = w_q;
					b_end_d = (w2 < n_e) ? w2 : n_e;
					k_d     = '0;
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (sel_q) begin
					we0 = 1'b1;
				end else begin
					we1 = 1'b1;
				end
				if (take_a) begin
					a_nxt = a_ptr_q + 1'b1;
				end else begin
					b_nxt = b_ptr_q + 1'b1;
				end
				k_d = k_q + 1'b1;
				if ((EW'(k_q) + 1'b1) == b_end_q) begin
					if (b_end_q == n_e) begin
						// pass done, runs now sit in the other memory
						w_d     = w2;
						sel_d   = ~sel_q;
						state_d = ST_PRIME;
					end else begin
						// second run starts where the first ends, empty at the tail
						a_nxt   = b_end_q;
						b_nxt   = nxt_a_end;
						a_end_d = nxt_a_end;
						b_end_d = nxt_b_end;
					end
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld = 1'b1;
					a_nxt  = a_ptr_q + 1'b1;
					if (a_ptr_q == (n_e - 1'b1)) begin
						state_d = ST_LOAD;
						count_d = '0;
						drop_d  = 1'b0;
					end
				end
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			drop_q     <= 1'b0;
			sel_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			drop_q  <= drop_d;
			sel_q   <= sel_d;
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// pointers and output payload
	always_ff @(posedge clk) begin
		w_q     <= w_d;
		a_ptr_q <= a_nxt;
		b_ptr_q <= b_nxt;
		a_end_q <= a_end_d;
		b_end_q <= b_end_d;
		k_q     <= k_d;
		if (out_ld) begin
			m_tdata_q <= rda;
			m_tlast_q <= (a_ptr_q == (n_e - 1'b1));
			m_tuser_q <= drop_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// element count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count above depth");

	// merge heads stay within their runs
	a_run_a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (a_ptr_q <= a_end_q))
		else $error("first run head past its end");

	a_run_b_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (b_ptr_q <= b_end_q))
		else $error("second run head past its end");

	// every merge write lands inside the set
	a_merge_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (k_q < count_q))
		else $error("merge write beyond set size");

	// a final result is followed by a return to loading
	a_last_leaves_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && (a_ptr_q == (n_e - 1'b1))) |=> (state_q == ST_LOAD))
		else $error("emission did not end after final result");
`endif

endmodule

// File: dv/merge_sort_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sort_engine_core_tb
// streams sets of signed words into the sort engine and checks every sorted
// result against a running prediction, with random sender gaps and receiver
// stalls
// ----------------------------------------------------------------------------

// one predicted result of a sorted set
typedef struct {
	logic [31:0] value;
	logic        final_res;
	logic        overflow;
} sorted_item_t;

// keeps the set being loaded in ascending order and turns it into the
// expected sorted results when the closing request arrives
class sorted_set_board;
	int           held_values[$];
	bit           values_dropped;
	sorted_item_t pending_sorted[$];
	int           errors;

	function new();
		values_dropped = 1'b0;
		errors         = 0;
	endfunction

	function int pending();
		return pending_sorted.size();
	endfunction

	// accepted input request: store or drop, then release the set on last
	function void note_request(logic [31:0] value, logic last);
		int           pos;
		sorted_item_t item;
		if (held_values.size() < mse_pkg::MSE_DEPTH) begin
			pos = 0;
			while (pos < held_values.size() && held_values[pos] <= int'(value))
				pos++;
			held_values.insert(pos, int'(value));
		end else begin
			values_dropped = 1'b1;
		end
		if (last) begin
			foreach (held_values[k]) begin
				item.value     = held_values[k];
				item.final_res = (k == held_values.size() - 1);
				item.overflow  = values_dropped;
				pending_sorted.push_back(item);
			end
			held_values.delete();
			values_dropped = 1'b0;
		end
	endfunction

	// accepted result: compare with the oldest expectation
	function void check_result(logic [31:0] value, logic final_res, logic overflow);
		sorted_item_t want;
		if (pending_sorted.size() == 0) begin
			$error("unexpected result: sorted_value %0d with nothing pending",
				$signed(value));
			errors++;
			return;
		end
		want = pending_sorted.pop_front();
		if (value !== want.value) begin
			$error("sorted_value: expected %0d, actual %0d",
				$signed(want.value), $signed(value));
			errors++;
		end
		if (final_res !== want.final_res) begin
			$error("final_res: expected %0b, actual %0b", want.final_res, final_res);
			errors++;
		end
		if (overflow !== want.overflow) begin
			$error("overflow: expected %0b, actual %0b", want.overflow, overflow);
			errors++;
		end
	endfunction
endclass

module merge_sort_engine_core_tb;
	import mse_pkg::*;

	localparam int unsigned ITEM_TARGET = 230;
	localparam int          INT_MIN     = 32'sh8000_0000;
	localparam int          INT_MAX     = 32'sh7fff_ffff;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	sorted_set_board board;
	int              burst_left;
	int              items_sent;

	merge_sort_engine_core #(
		.DEPTH(MSE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("merge_sort_engine_core regression: fail");
		$finish;
	end

	// one request on the input side, with a random gap at the start of a burst
	task automatic send_request(input logic [31:0] value, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		board.note_request(value, last);
		items_sent++;
	endtask

	task automatic send_set(input int set_vals[$]);
		foreach (set_vals[k])
			send_request(set_vals[k], k == set_vals.size() - 1);
	endtask

	// value mix: full range, a narrow band for duplicates, or an extreme
	function automatic int pick_value();
		int extremes[5];
		extremes = '{INT_MIN, INT_MAX, 0, -1, 1};
		case ($urandom_range(0, 5))
			0:       return int'($urandom_range(0, 15)) - 8;
			1:       return extremes[$urandom_range(0, 4)];
			default: return int'($urandom());
		endcase
	endfunction

	// receiver: phases of always ready, random ready and long stalls
	initial begin
		int style;
		int phase_len;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			style     = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 120);
			repeat (phase_len) begin
				@(negedge clk);
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tlast, m_tuser);
	end

	initial begin
		int set_vals[$];
		int set_idx;
		int set_len;
		board      = new();
		burst_left = 0;
		items_sent = 0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		arst_n     = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: single element set
		set_vals = '{42};
		send_set(set_vals);
		// extremes of the range, closing on a small positive value
		set_vals = '{INT_MAX, INT_MIN, 0, -1, 1};
		send_set(set_vals);
		// repeated values
		set_vals = '{5, 5, -5, 5, -5, 5};
		send_set(set_vals);
		// two elements in descending order
		set_vals = '{7, -7};
		send_set(set_vals);
		// alternating bit patterns and values next to the extremes
		set_vals = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh8000_0001, 32'sh7fff_fffe};
		send_set(set_vals);

		// random sets, one exactly filling the store and one that overflows it
		// (its closing request is dropped but still ends the set)
		set_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			if (set_idx == 2)
				set_len = MSE_DEPTH;
			else if (set_idx == 5)
				set_len = MSE_DEPTH + 2;
			else if ($urandom_range(0, 4) == 0)
				set_len = $urandom_range(11, 40);
			else
				set_len = $urandom_range(1, 10);
			set_vals.delete();
			repeat (set_len) set_vals.push_back(pick_value());
			send_set(set_vals);
			set_idx++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// drain, then watch a while for stray results
		while (board.pending() != 0) @(posedge clk);
		repeat (500) @(posedge clk);

		if (board.errors == 0)
			$display("merge_sort_engine_core regression: pass");
		else
			$display("merge_sort_engine_core regression: fail");
		$finish;
	end

endmodule
